// ===== rtl/tmvv_pkg.sv =====
// Package for the trimmed-mean vertical velocity estimator.
// Holds field widths, register indexes, reset values, FSM and control types.
// No dependencies.
package tmvv_pkg;

    localparam int ACCEL_W   = 16;
    localparam int HEIGHT_W  = 21;
    localparam int VEL_W     = 32;
    localparam int GRAV_W    = 11;
    localparam int DZ_W      = 15;
    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 1;
    localparam int HD_W      = HEIGHT_W + 1;   // height difference
    localparam int HD100_W   = HD_W + 7;       // height difference times 100

    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE = 1'b1;

    localparam logic [GRAV_W-1:0] GRAVITY_RESET   = 11'd981;
    localparam logic [DZ_W-1:0]   DEAD_ZONE_RESET = 15'd300;

    localparam logic signed [HD100_W-1:0] HEIGHT_SCALE = 29'sd100;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_TRIM,
        ST_START,
        ST_DIV,
        ST_ACC,
        ST_OUT
    } t_tmvv_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic rd_en;
        logic first;
        logic trim;
        logic div_start;
        logic acc;
        logic load_out;
    } t_tmvv_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_tmvv_sts;

    // Saturate a 33-bit signed sum to 32 bits
    function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [VEL_W:0] v);
        logic signed [VEL_W-1:0] r;
        if (v[VEL_W] != v[VEL_W-1]) begin
            r = v[VEL_W] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
        end else begin
            r = v[VEL_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/tmvv_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tmvv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 25,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ===== rtl/tmvv_div.sv =====
// Division by a constant through a reciprocal multiply, quotient registered the cycle after start.
// No dependencies.
module tmvv_div #(
    parameter int W       = 21,
    parameter int DIVISOR = 23,
    localparam int SHIFT = W + $clog2(DIVISOR) + 1,
    localparam int MW    = W + 3,
    localparam int PW    = W + MW
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    output logic [W-1:0] o_quotient,
    output logic         o_done
);

    // Reciprocal rounded up; its excess times any W-bit dividend stays below 2^SHIFT,
    // so the integer part of the product is the exact quotient
    localparam logic [MW-1:0] RECIP_C =
        MW'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic [PW-1:0] w_product;
    logic [W-1:0]  r_quo;
    logic          r_done;

    // Multiply by the reciprocal
    assign w_product = PW'(i_dividend) * PW'(RECIP_C);

    // Done pulse in the cycle after start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    // Keep the integer part of the product
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= W'(w_product[PW-1:SHIFT]);
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

// ===== rtl/tmvv_datapath.sv =====
// Datapath: sample window, sum/max/min walk, trimmed mean, velocity accumulator.
// Depends on tmvv_pkg, tmvv_ram and tmvv_div.
module tmvv_datapath #(
    parameter int WINDOW_SIZE = 25,
    localparam int AW = $clog2(WINDOW_SIZE)
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  tmvv_pkg::t_tmvv_cmd                   i_cmd,
    input  logic [AW-1:0]                         i_rd_addr,
    output tmvv_pkg::t_tmvv_sts                   o_sts,
    input  logic                                  i_cfg_we,
    input  logic [tmvv_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [tmvv_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic signed [tmvv_pkg::ACCEL_W-1:0]   i_vertical_accel,
    input  logic signed [tmvv_pkg::HEIGHT_W-1:0]  i_height_cm,
    input  logic                                  i_ready,
    output logic                                  o_valid,
    output logic signed [tmvv_pkg::ACCEL_W-1:0]   o_trimmed_accel,
    output logic signed [tmvv_pkg::VEL_W-1:0]     o_velocity_sum,
    output logic signed [tmvv_pkg::VEL_W-1:0]     o_velocity_estimate
);

    localparam int AWD     = tmvv_pkg::ACCEL_W;
    localparam int SUM_W   = AWD + AW + 1;
    localparam int MAG_W   = SUM_W - 1;
    localparam int DIVISOR = WINDOW_SIZE - 2;
    localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW_SIZE - 1);

    // Configuration registers
    logic [tmvv_pkg::GRAV_W-1:0] r_gravity;
    logic [tmvv_pkg::DZ_W-1:0]   r_dead_zone;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity   <= tmvv_pkg::GRAVITY_RESET;
            r_dead_zone <= tmvv_pkg::DEAD_ZONE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tmvv_pkg::CFG_GRAVITY:   r_gravity   <= i_cfg_data[tmvv_pkg::GRAV_W-1:0];
                tmvv_pkg::CFG_DEAD_ZONE: r_dead_zone <= i_cfg_data[tmvv_pkg::DZ_W-1:0];
                default: ;
            endcase
        end
    end

    // Subtract gravity and clamp the low side
    logic signed [AWD:0]   w_diff;
    logic signed [AWD-1:0] w_sample;

    assign w_diff = $signed({i_vertical_accel[AWD-1], i_vertical_accel})
                  - $signed({{(AWD + 1 - tmvv_pkg::GRAV_W){1'b0}}, r_gravity});
    assign w_sample = (w_diff[AWD] & ~w_diff[AWD-1]) ? {1'b1, {(AWD-1){1'b0}}}
                                                     : w_diff[AWD-1:0];

    // Write slot, valid bits and captured height
    logic [AW-1:0]                       r_slot;
    logic [WINDOW_SIZE-1:0]              r_valid;
    logic signed [tmvv_pkg::HEIGHT_W-1:0] r_height;
    logic signed [tmvv_pkg::HEIGHT_W-1:0] r_prev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_valid <= '0;
        end else if (i_cmd.capture) begin
            r_valid[r_slot] <= 1'b1;
            r_slot <= (r_slot == LAST_SLOT) ? '0 : (r_slot + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_height <= i_height_cm;
        end
    end

    // Window memory
    logic [AWD-1:0] w_rdata;

    tmvv_ram #(
        .WIDTH (AWD),
        .DEPTH (WINDOW_SIZE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.capture),
        .i_waddr (r_slot),
        .i_wdata (w_sample),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_rd_addr),
        .o_rdata (w_rdata)
    );

    // Track each read beat in the cycle after its address, when its read data arrives
    logic r_rd_pend;
    logic r_rd_first;
    logic r_rd_vbit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_first <= i_cmd.first;
        r_rd_vbit  <= r_valid[i_rd_addr];
    end

    // Accumulate sum, max and min over the window; unwritten entries read zero
    logic signed [AWD-1:0]   w_elem;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [AWD-1:0]   r_max;
    logic signed [AWD-1:0]   r_min;

    assign w_elem = r_rd_vbit ? $signed(w_rdata) : '0;

    always_ff @(posedge i_clk) begin
        if (r_rd_pend) begin
            if (r_rd_first) begin
                r_sum <= SUM_W'(w_elem);
                r_max <= w_elem;
                r_min <= w_elem;
            end else begin
                r_sum <= r_sum + SUM_W'(w_elem);
                if (w_elem > r_max) begin
                    r_max <= w_elem;
                end
                if (w_elem < r_min) begin
                    r_min <= w_elem;
                end
            end
        end
    end

    // Drop the extremes
    logic signed [SUM_W-1:0] r_trim;
    logic                    r_neg;
    logic [SUM_W-1:0]        w_abs;

    always_ff @(posedge i_clk) begin
        if (i_cmd.trim) begin
            r_trim <= r_sum - SUM_W'(r_max) - SUM_W'(r_min);
        end
    end

    assign w_abs = r_trim[SUM_W-1] ? SUM_W'(-r_trim) : r_trim;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_neg <= r_trim[SUM_W-1];
        end
    end

    // Divide the magnitude by WINDOW_SIZE - 2
    logic [MAG_W-1:0] w_quo;
    logic             w_div_done;

    tmvv_div #(
        .W       (MAG_W),
        .DIVISOR (DIVISOR)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_abs[MAG_W-1:0]),
        .o_quotient (w_quo),
        .o_done     (w_div_done)
    );

    // Restore sign, apply dead zone and integrate
    logic [AWD:0]                          w_quo_n;
    logic signed [AWD:0]                   w_mean_x;
    logic signed [AWD-1:0]                 w_mean;
    logic                                  w_integrate;
    logic signed [tmvv_pkg::VEL_W:0]       w_acc_sum;
    logic signed [tmvv_pkg::HD_W-1:0]      w_hd;
    logic signed [tmvv_pkg::HD100_W-1:0]   w_hd_x;
    logic signed [tmvv_pkg::HD100_W-1:0]   r_hd100;
    logic signed [tmvv_pkg::VEL_W-1:0]     r_acc;
    logic signed [AWD-1:0]                 r_mean;
    logic signed [tmvv_pkg::VEL_W:0]       w_est_sum;

    assign w_quo_n     = w_quo[AWD:0];
    assign w_mean_x    = r_neg ? $signed(-w_quo_n) : $signed(w_quo_n);
    assign w_mean      = w_mean_x[AWD-1:0];
    assign w_integrate = (w_quo > MAG_W'(r_dead_zone));
    assign w_acc_sum   = (tmvv_pkg::VEL_W + 1)'(r_acc) + (tmvv_pkg::VEL_W + 1)'(w_mean);
    assign w_hd        = tmvv_pkg::HD_W'(r_height) - tmvv_pkg::HD_W'(r_prev);
    assign w_hd_x      = tmvv_pkg::HD100_W'(w_hd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_cmd.acc && w_integrate) begin
            r_acc <= tmvv_pkg::sat_vel(w_acc_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            r_mean  <= w_mean;
            r_hd100 <= w_hd_x * tmvv_pkg::HEIGHT_SCALE;
        end
    end

    // Velocity estimate and output register
    assign w_est_sum = (tmvv_pkg::VEL_W + 1)'(r_acc) + (tmvv_pkg::VEL_W + 1)'(r_hd100);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            r_prev  <= '0;
        end else begin
            if (i_cmd.load_out) begin
                o_valid <= 1'b1;
                r_prev  <= r_height;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_trimmed_accel     <= r_mean;
            o_velocity_sum      <= r_acc;
            o_velocity_estimate <= tmvv_pkg::sat_vel(w_est_sum);
        end
    end

    // Status back to the controller
    assign o_sts.div_done = w_div_done;
    assign o_sts.out_free = ~o_valid | i_ready;

endmodule

// ===== rtl/tmvv_ctrl.sv =====
// Controller FSM: sequences capture, window walk, division, integrate and output.
// Depends on tmvv_pkg.
module tmvv_ctrl #(
    parameter int WINDOW_SIZE = 25,
    localparam int AW = $clog2(WINDOW_SIZE)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  tmvv_pkg::t_tmvv_sts i_sts,
    output tmvv_pkg::t_tmvv_cmd o_cmd,
    output logic [AW-1:0]       o_rd_addr
);

    localparam logic [AW-1:0] LAST_IDX = AW'(WINDOW_SIZE - 1);

    tmvv_pkg::t_tmvv_state r_state;
    tmvv_pkg::t_tmvv_state n_state;
    logic [AW-1:0]         r_idx;

    // State register and walk counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tmvv_pkg::ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == tmvv_pkg::ST_WALK) begin
                r_idx <= r_idx + 1'b1;
            end else begin
                r_idx <= '0;
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tmvv_pkg::ST_IDLE:  if (i_valid) n_state = tmvv_pkg::ST_WALK;
            tmvv_pkg::ST_WALK:  if (r_idx == LAST_IDX) n_state = tmvv_pkg::ST_DRAIN;
            tmvv_pkg::ST_DRAIN: n_state = tmvv_pkg::ST_TRIM;
            tmvv_pkg::ST_TRIM:  n_state = tmvv_pkg::ST_START;
            tmvv_pkg::ST_START: n_state = tmvv_pkg::ST_DIV;
            tmvv_pkg::ST_DIV:   if (i_sts.div_done) n_state = tmvv_pkg::ST_ACC;
            tmvv_pkg::ST_ACC:   n_state = tmvv_pkg::ST_OUT;
            tmvv_pkg::ST_OUT:   if (i_sts.out_free) n_state = tmvv_pkg::ST_IDLE;
            default:            n_state = tmvv_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_ready         = (r_state == tmvv_pkg::ST_IDLE);
        o_cmd           = '0;
        o_cmd.capture   = (r_state == tmvv_pkg::ST_IDLE) && i_valid;
        o_cmd.rd_en     = (r_state == tmvv_pkg::ST_WALK);
        o_cmd.first     = (r_state == tmvv_pkg::ST_WALK) && (r_idx == '0);
        o_cmd.trim      = (r_state == tmvv_pkg::ST_TRIM);
        o_cmd.div_start = (r_state == tmvv_pkg::ST_START);
        o_cmd.acc       = (r_state == tmvv_pkg::ST_ACC);
        o_cmd.load_out  = (r_state == tmvv_pkg::ST_OUT) && i_sts.out_free;
        o_rd_addr       = r_idx;
    end

endmodule

// ===== rtl/trimmed_mean_vertical_velocity.sv =====
// Top level of the trimmed-mean vertical velocity estimator.
// Depends on tmvv_pkg, tmvv_ctrl and tmvv_datapath.
//
//  channel  direction  handshake               payload
//  input    in         i_valid / o_ready       i_vertical_accel, i_height_cm
//  output   out        o_valid / i_ready       o_trimmed_accel, o_velocity_sum,
//                                              o_velocity_estimate
//  config   in         i_cfg_we (no wait)      i_cfg_idx, i_cfg_data
//
// One item at a time. From accept to o_valid an item passes through a walk with one read
// per window entry from the window RAM, then drain, trim, divide (one reciprocal multiply),
// its done state, integrate and output load. The next item is accepted the cycle after
// the output register loads; a stalled result only holds the block in its final step.
// Reset is synchronous; the window is cleared at once through per-entry valid bits.
module trimmed_mean_vertical_velocity #(
    parameter int WINDOW_SIZE = 25
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [tmvv_pkg::ACCEL_W-1:0]   i_vertical_accel,
    input  logic signed [tmvv_pkg::HEIGHT_W-1:0]  i_height_cm,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [tmvv_pkg::ACCEL_W-1:0]   o_trimmed_accel,
    output logic signed [tmvv_pkg::VEL_W-1:0]     o_velocity_sum,
    output logic signed [tmvv_pkg::VEL_W-1:0]     o_velocity_estimate,
    input  logic                                  i_cfg_we,
    input  logic [tmvv_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [tmvv_pkg::CFG_W-1:0]            i_cfg_data
);

    localparam int AW = $clog2(WINDOW_SIZE);

    tmvv_pkg::t_tmvv_cmd w_cmd;
    tmvv_pkg::t_tmvv_sts w_sts;
    logic [AW-1:0]       w_rd_addr;

    // Sequencer
    tmvv_ctrl #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd),
        .o_rd_addr (w_rd_addr)
    );

    // Arithmetic and storage
    tmvv_datapath #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .i_rd_addr           (w_rd_addr),
        .o_sts               (w_sts),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_vertical_accel    (i_vertical_accel),
        .i_height_cm         (i_height_cm),
        .i_ready             (i_ready),
        .o_valid             (o_valid),
        .o_trimmed_accel     (o_trimmed_accel),
        .o_velocity_sum      (o_velocity_sum),
        .o_velocity_estimate (o_velocity_estimate)
    );

endmodule

// ===== rtl/tmvv_checker.sv =====
// Port-level checker for the trimmed-mean vertical velocity estimator, with its bind.
// Depends on tmvv_pkg and trimmed_mean_vertical_velocity.
module tmvv_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_valid,
    input logic                                  o_ready,
    input logic signed [tmvv_pkg::ACCEL_W-1:0]   i_vertical_accel,
    input logic signed [tmvv_pkg::HEIGHT_W-1:0]  i_height_cm,
    input logic                                  o_valid,
    input logic                                  i_ready,
    input logic signed [tmvv_pkg::ACCEL_W-1:0]   o_trimmed_accel,
    input logic signed [tmvv_pkg::VEL_W-1:0]     o_velocity_sum,
    input logic signed [tmvv_pkg::VEL_W-1:0]     o_velocity_estimate,
    input logic                                  i_cfg_we,
    input logic [tmvv_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input logic [tmvv_pkg::CFG_W-1:0]            i_cfg_data
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_trimmed_accel)
            && $stable(o_velocity_sum) && $stable(o_velocity_estimate)))
        else $error("result changed while stalled");

    // One item in flight: drop ready right after an accepted beat
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second item accepted while busy");

    // A result never appears the cycle after an accept
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !(o_valid && !$past(o_valid)))
        else $error("result produced too early");

    // Reset leaves no result pending
    a_reset_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_valid)
        else $error("result valid after reset");

endmodule

bind trimmed_mean_vertical_velocity tmvv_checker u_tmvv_checker (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for trimmed_mean_vertical_velocity: random and directed samples checked
// against a cycle-free model of the gravity removal, trimmed window mean and velocity.
// Depends on tmvv_pkg and the RTL of trimmed_mean_vertical_velocity.
module tb_top;

    localparam int WINDOW_DEPTH    = 25;
    localparam int RESET_CYCLES    = 7;
    localparam int MAX_GAP         = 16;
    localparam int HOLDOFF_CYCLES  = 300;
    localparam int PHASE_COUNT     = 7;
    localparam int PHASE_ITEMS     = 95;
    localparam int PAUSE_ITEMS     = 12;
    // beats of the most negative sample that push the accumulator down hard
    localparam int DRIVE_ITEMS     = 48;
    localparam int EXTREME_HEIGHTS = 16;
    // a quiet stretch can hold a whole item, a full gap, a stall and the hold-off
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int TAIL_CYCLES     = 64;
    localparam int MAX_REPORTS     = 10;

    localparam int ACCEL_MAX  = 32767;
    localparam int ACCEL_MIN  = -32768;
    localparam int HEIGHT_MAX = 1048575;
    localparam int HEIGHT_MIN = -1048576;
    localparam longint VEL_MAX = 64'sd2147483647;
    localparam longint VEL_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [tmvv_pkg::ACCEL_W-1:0] trimmed;
        logic signed [tmvv_pkg::VEL_W-1:0]   vsum;
        logic signed [tmvv_pkg::VEL_W-1:0]   estimate;
    } t_velocity_result;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_valid;
    logic                                 o_ready;
    logic signed [tmvv_pkg::ACCEL_W-1:0]  i_vertical_accel;
    logic signed [tmvv_pkg::HEIGHT_W-1:0] i_height_cm;
    logic                                 o_valid;
    logic                                 i_ready;
    logic signed [tmvv_pkg::ACCEL_W-1:0]  o_trimmed_accel;
    logic signed [tmvv_pkg::VEL_W-1:0]    o_velocity_sum;
    logic signed [tmvv_pkg::VEL_W-1:0]    o_velocity_estimate;
    logic                                 i_cfg_we;
    logic [tmvv_pkg::CFG_IDX_W-1:0]       i_cfg_idx;
    logic [tmvv_pkg::CFG_W-1:0]           i_cfg_data;

    // model state, mirrors the block after reset
    logic signed [tmvv_pkg::ACCEL_W-1:0]  window_model [WINDOW_DEPTH] = '{default: '0};
    int                                   window_slot   = 0;
    logic signed [tmvv_pkg::VEL_W-1:0]    velocity_acc  = '0;
    logic signed [tmvv_pkg::HEIGHT_W-1:0] last_height   = '0;
    logic [tmvv_pkg::GRAV_W-1:0]          gravity_cfg   = tmvv_pkg::GRAVITY_RESET;
    logic [tmvv_pkg::DZ_W-1:0]            dead_zone_cfg = tmvv_pkg::DEAD_ZONE_RESET;

    t_velocity_result expected_results [$];

    bit tx_stall_on = 1'b1;
    bit rx_stall_on = 1'b1;
    int rx_holdoff  = 0;
    int height_walk = 0;

    int samples_sent    = 0;
    int results_checked = 0;
    int mismatches      = 0;
    int config_writes   = 0;
    int quiet_cycles    = 0;

    trimmed_mean_vertical_velocity #(
        .WINDOW_SIZE(WINDOW_DEPTH)
    ) u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_vertical_accel   (i_vertical_accel),
        .i_height_cm        (i_height_cm),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_trimmed_accel    (o_trimmed_accel),
        .o_velocity_sum     (o_velocity_sum),
        .o_velocity_estimate(o_velocity_estimate),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic longint clamp_to_int32(input longint v);
        if (v > VEL_MAX) return VEL_MAX;
        if (v < VEL_MIN) return VEL_MIN;
        return v;
    endfunction

    function automatic int clip_int(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Advance the model by one sample and return the result it causes
    function automatic t_velocity_result step_velocity_model(
        input logic signed [tmvv_pkg::ACCEL_W-1:0]  accel,
        input logic signed [tmvv_pkg::HEIGHT_W-1:0] height
    );
        t_velocity_result r;
        longint           diff;
        longint           total;
        longint           hi;
        longint           lo;
        longint           mean;
        longint           mag;
        int               k;
        diff = longint'(accel) - longint'(gravity_cfg);
        if (diff < longint'(ACCEL_MIN)) diff = longint'(ACCEL_MIN);
        if (diff > longint'(ACCEL_MAX)) diff = longint'(ACCEL_MAX);
        window_model[window_slot] = diff[tmvv_pkg::ACCEL_W-1:0];
        window_slot = (window_slot == WINDOW_DEPTH - 1) ? 0 : window_slot + 1;

        // drop exactly one largest and one smallest entry
        total = 0;
        hi = longint'(window_model[0]);
        lo = longint'(window_model[0]);
        for (k = 0; k < WINDOW_DEPTH; k++) begin
            total += longint'(window_model[k]);
            if (longint'(window_model[k]) > hi) hi = longint'(window_model[k]);
            if (longint'(window_model[k]) < lo) lo = longint'(window_model[k]);
        end
        mean = (total - hi - lo) / longint'(WINDOW_DEPTH - 2);

        mag = (mean < 0) ? -mean : mean;
        if (mag > longint'(dead_zone_cfg)) begin
            velocity_acc = tmvv_pkg::VEL_W'(clamp_to_int32(longint'(velocity_acc) + mean));
        end
        r.trimmed  = mean[tmvv_pkg::ACCEL_W-1:0];
        r.vsum     = velocity_acc;
        r.estimate = tmvv_pkg::VEL_W'(clamp_to_int32(longint'(velocity_acc)
                     + 100 * (longint'(height) - longint'(last_height))));
        last_height = height;
        return r;
    endfunction

    // Half of the samples near gravity so the mean hovers around the dead zone
    function automatic int pick_accel();
        int          sel;
        int          v;
        logic [31:0] raw;
        sel = int'($urandom_range(99));
        raw = $urandom();
        if (sel < 50) begin
            v = int'(gravity_cfg) + int'($urandom_range(4000)) - 2000;
        end else if (sel < 80) begin
            v = int'($signed(raw[tmvv_pkg::ACCEL_W-1:0]));
        end else begin
            v = raw[0] ? ACCEL_MAX : ACCEL_MIN;
        end
        return clip_int(v, ACCEL_MIN, ACCEL_MAX);
    endfunction

    // Smooth height walk with the odd jump anywhere or to a limit
    function automatic int pick_height();
        int          sel;
        logic [31:0] raw;
        sel = int'($urandom_range(99));
        raw = $urandom();
        if (sel < 60) begin
            height_walk = height_walk + int'($urandom_range(1000)) - 500;
        end else if (sel < 80) begin
            height_walk = int'($signed(raw[tmvv_pkg::HEIGHT_W-1:0]));
        end else begin
            height_walk = raw[0] ? HEIGHT_MAX : HEIGHT_MIN;
        end
        height_walk = clip_int(height_walk, HEIGHT_MIN, HEIGHT_MAX);
        return height_walk;
    endfunction

    // Offer one sample after a random gap and hold it until accepted
    task automatic send_sample(input int accel, input int height);
        int gap;
        gap = tx_stall_on ? int'($urandom_range(MAX_GAP)) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_vertical_accel <= accel[tmvv_pkg::ACCEL_W-1:0];
        i_height_cm      <= height[tmvv_pkg::HEIGHT_W-1:0];
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(
        input logic [tmvv_pkg::CFG_IDX_W-1:0] idx,
        input logic [tmvv_pkg::CFG_W-1:0]     data
    );
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == tmvv_pkg::CFG_GRAVITY) begin
            gravity_cfg = data[tmvv_pkg::GRAV_W-1:0];
        end else begin
            dead_zone_cfg = data[tmvv_pkg::DZ_W-1:0];
        end
        config_writes++;
        @(posedge i_clk);
    endtask

    // Reprogram both registers while the block is idle
    task automatic set_config(input int gravity, input int dead_zone);
        logic [tmvv_pkg::CFG_W-1:0] data;
        wait_for_drain();
        // unused upper data bits carry noise on the gravity write
        data = tmvv_pkg::CFG_W'($urandom());
        data[tmvv_pkg::GRAV_W-1:0] = gravity[tmvv_pkg::GRAV_W-1:0];
        write_register(tmvv_pkg::CFG_GRAVITY, data);
        write_register(tmvv_pkg::CFG_DEAD_ZONE, dead_zone[tmvv_pkg::DZ_W-1:0]);
    endtask

    // Reset values, a gravity-free window and a first height taken against zero
    task automatic test_first_items();
        send_sample(981, HEIGHT_MAX);
        send_sample(981, HEIGHT_MIN);
    endtask

    // Mean equal to the dead zone stays out, a mean above it goes in
    task automatic test_dead_zone_edge();
        set_config(0, 7);
        send_sample(161, 0);
        send_sample(161, 0);
        send_sample(161, 5);
        set_config(0, 0);
        send_sample(-161, -1);
        send_sample(-23, 0);
    endtask

    // Sample saturation and limit values held in the window
    task automatic test_sample_extremes();
        set_config(2047, 300);
        send_sample(ACCEL_MIN, HEIGHT_MAX);
        send_sample(ACCEL_MAX, HEIGHT_MIN);
        set_config(0, 32767);
        send_sample(ACCEL_MAX, 0);
        send_sample(ACCEL_MIN, 1);
        send_sample(0, -1);
        send_sample(-1, 0);
        set_config(0, 0);
        send_sample(ACCEL_MAX, HEIGHT_MIN);
        send_sample(ACCEL_MIN, HEIGHT_MAX);
        send_sample(1, 0);
    endtask

    // Random samples under a sweep of settings and idling patterns
    task automatic test_random_traffic();
        int p;
        int g;
        int dz;
        for (p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: begin
                    g  = int'(tmvv_pkg::GRAVITY_RESET);
                    dz = int'(tmvv_pkg::DEAD_ZONE_RESET);
                end
                1: begin
                    g  = 0;
                    dz = 0;
                end
                2: begin
                    g  = 2047;
                    dz = 32767;
                end
                3: begin
                    g  = 2047;
                    dz = 0;
                end
                4: begin
                    g  = 0;
                    dz = 32767;
                end
                default: begin
                    g  = int'($urandom_range(2047));
                    dz = int'($urandom_range(1000));
                end
            endcase
            set_config(g, dz);
            tx_stall_on = (p != 2) && (p != 5);
            rx_stall_on = (p != 1) && (p != 5);
            repeat (PHASE_ITEMS) send_sample(pick_accel(), pick_height());
        end
        tx_stall_on = 1'b1;
        rx_stall_on = 1'b1;
    endtask

    // Hold off the output so the block fills and stalls its input
    task automatic test_output_holdoff();
        wait_for_drain();
        tx_stall_on = 1'b0;
        rx_holdoff  = HOLDOFF_CYCLES;
        repeat (4) send_sample(pick_accel(), pick_height());
        tx_stall_on = 1'b1;
    endtask

    // Sender waits for every result before the next beat
    task automatic test_sender_pause();
        repeat (PAUSE_ITEMS) begin
            send_sample(pick_accel(), pick_height());
            wait_for_drain();
        end
    endtask

    // Drive the accumulator down hard, then swing the height between its limits
    task automatic test_velocity_drive();
        int n;
        set_config(2047, 0);
        tx_stall_on = 1'b0;
        rx_stall_on = 1'b0;
        for (n = 0; n < DRIVE_ITEMS; n++) begin
            if (n < DRIVE_ITEMS - EXTREME_HEIGHTS) begin
                send_sample(ACCEL_MIN, pick_height());
            end else begin
                send_sample(ACCEL_MIN, n[0] ? HEIGHT_MIN : HEIGHT_MAX);
            end
        end
        tx_stall_on = 1'b1;
        rx_stall_on = 1'b1;
    endtask

    // Predict on every accepted input beat
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            expected_results.push_back(step_velocity_model(i_vertical_accel, i_height_cm));
            samples_sent++;
        end
    end

    // Check every accepted result beat against the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_velocity_result want;
        if (i_rst_n && o_valid && i_ready) begin
            results_checked++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected result beat: trimmed %0d sum %0d estimate %0d",
                             o_trimmed_accel, o_velocity_sum, o_velocity_estimate);
                end
            end else begin
                want = expected_results.pop_front();
                if (o_trimmed_accel !== want.trimmed || o_velocity_sum !== want.vsum
                        || o_velocity_estimate !== want.estimate) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("result %0d: trimmed exp %0d got %0d", results_checked,
                                 want.trimmed, o_trimmed_accel);
                        $display("  velocity sum exp %0d got %0d, estimate exp %0d got %0d",
                                 want.vsum, o_velocity_sum, want.estimate,
                                 o_velocity_estimate);
                    end
                end
            end
        end
    end

    // Receiver: random stall before each result, plus the requested hold-off
    initial begin
        int stall;
        i_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = rx_stall_on ? int'($urandom_range(MAX_GAP)) : 0;
            if (rx_holdoff > 0) begin
                stall = rx_holdoff;
                rx_holdoff = 0;
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     quiet_cycles, expected_results.size());
            $display("trimmed_mean_vertical_velocity verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_vertical_accel = '0;
        i_height_cm      = '0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = tmvv_pkg::CFG_GRAVITY;
        i_cfg_data       = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_first_items();
        test_dead_zone_edge();
        test_sample_extremes();
        test_random_traffic();
        test_output_holdoff();
        test_sender_pause();
        test_velocity_drive();

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        mismatches += expected_results.size();

        $display("covered %0d samples and %0d checked results over %0d register writes,",
                 samples_sent, results_checked, config_writes);
        $display("with a %0d-cycle output hold-off and a hard drive of the accumulator",
                 HOLDOFF_CYCLES);
        if (mismatches == 0) begin
            $display("trimmed_mean_vertical_velocity verification clean");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("trimmed_mean_vertical_velocity verification failed");
        end
        $finish;
    end

endmodule
